FILE: src/trimmed_mean_piecewise_voltage_unit_defines.svh
// Assertion macros shared by the trimmed mean voltage unit.
// Each use names a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef TRIMMED_MEAN_PIECEWISE_VOLTAGE_UNIT_DEFINES_SVH
`define TRIMMED_MEAN_PIECEWISE_VOLTAGE_UNIT_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define TMPV_ASSERT_SAME(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("tmpv assertion failed");

// The property must hold in the cycle after the condition.
`define TMPV_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tmpv assertion failed");

`endif

FILE: src/tmpv_pkg.sv
`timescale 1ns / 1ps

package tmpv_pkg;

  // Field widths.
  localparam int unsigned SampleW = 12;
  localparam int unsigned GainW   = 16;
  localparam int unsigned MvW     = 16;
  localparam int unsigned ProdW   = SampleW + GainW;

  // Largest calibrated value: floor(4095 * 57000 / 4059).
  localparam longint unsigned MvMax = 57505;

  // Upper code limits of the calibration segments.
  localparam logic [SampleW-1:0] Seg0Top = 12'd498;
  localparam logic [SampleW-1:0] Seg1Top = 12'd639;
  localparam logic [SampleW-1:0] Seg2Top = 12'd849;
  localparam logic [SampleW-1:0] Seg3Top = 12'd1060;
  localparam logic [SampleW-1:0] Seg4Top = 12'd1266;

  // Gain words, one for each segment (slope times 4059, rounded).
  localparam logic [GainW-1:0] Gain0 = 16'd55573;
  localparam logic [GainW-1:0] Gain1 = 16'd56500;
  localparam logic [GainW-1:0] Gain2 = 16'd56625;
  localparam logic [GainW-1:0] Gain3 = 16'd56750;
  localparam logic [GainW-1:0] Gain4 = 16'd56875;
  localparam logic [GainW-1:0] Gain5 = 16'd57000;

  // Division by the calibration divisor is done as a multiply by a rounded-up
  // reciprocal. With the shift at ProdW plus 12 bits the quotient is exact for
  // every product below 2**ProdW.
  localparam longint unsigned CalDivisor = 4059;
  localparam int unsigned     CalShift   = ProdW + 12;
  localparam int unsigned     CalRecipW  = ProdW + 1;
  localparam logic [CalRecipW-1:0] CalRecip =
    CalRecipW'(((64'd1 << CalShift) + CalDivisor - 64'd1) / CalDivisor);

endpackage

FILE: src/tmpv_if.sv
`timescale 1ns / 1ps

// Channel that carries one raw ADC code per item.
interface tmpv_sample_if;
  import tmpv_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Channel that carries one calibrated result per item.
interface tmpv_result_if;
  import tmpv_pkg::*;

  logic           valid;
  logic           ready;
  logic [MvW-1:0] instant_mv;
  logic [MvW-1:0] average_mv;
  logic           window_done;

  modport source (output valid, output instant_mv, output average_mv, output window_done,
                  input ready);
  modport sink   (input valid, input instant_mv, input average_mv, input window_done,
                  output ready);
endinterface

FILE: src/trimmed_mean_piecewise_voltage_unit.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; five registered
// stages, each with its own valid bit, so a gap anywhere in the pipe is
// filled while the output waits.
// Reset (rst_ni low, asynchronous) empties the pipe and clears the window
// count, sum, maximum and minimum; payload registers are not reset.
`include "trimmed_mean_piecewise_voltage_unit_defines.svh"

module trimmed_mean_piecewise_voltage_unit #(
  parameter int unsigned WINDOW_LEN = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tmpv_sample_if.sink   sample_i,
  tmpv_result_if.source result_o
);
  import tmpv_pkg::*;

  // The trimmed mean divides by the window length less the two dropped values.
  localparam longint unsigned AvgDiv  = longint'(WINDOW_LEN) - 64'd2;
  localparam int unsigned     CntW    = $clog2(WINDOW_LEN);
  // The running sum holds a full window of maximal values without wrapping.
  localparam int unsigned     SumW    = $clog2(longint'(WINDOW_LEN) * MvMax + 64'd1);
  // Reciprocal of the divisor, rounded up; the shift of SumW plus the ceiling of
  // log2 of the divisor makes the quotient exact for every sum that fits SumW bits.
  localparam int unsigned     AvgShift  = SumW + $clog2(AvgDiv);
  localparam int unsigned     AvgRecipW = SumW + 1;
  localparam logic [AvgRecipW-1:0] AvgRecip =
    AvgRecipW'(((64'd1 << AvgShift) + AvgDiv - 64'd1) / AvgDiv);
  localparam int unsigned     AvgProdW  = SumW + AvgRecipW;
  localparam int unsigned     CalProdW  = ProdW + CalRecipW;
  localparam logic [CntW-1:0] LastCnt   = CntW'(WINDOW_LEN - 1);

  // ---------------------------------------------------------------------------
  // Stage handshake. Each stage loads when it is empty or when the stage after
  // it moves on, so the pipe keeps accepting as long as any stage has room.
  // ---------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || result_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign sample_i.ready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= sample_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------------
  logic [SampleW-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (rdy0) sample_q <= sample_i.sample;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick the gain word by code range and form the raw product.
  // ---------------------------------------------------------------------------
  logic [GainW-1:0] gain;
  logic [ProdW-1:0] prod_q;

  always_comb begin
    priority if (sample_q <= Seg0Top) gain = Gain0;
    else if (sample_q <= Seg1Top)      gain = Gain1;
    else if (sample_q <= Seg2Top)      gain = Gain2;
    else if (sample_q <= Seg3Top)      gain = Gain3;
    else if (sample_q <= Seg4Top)      gain = Gain4;
    else                               gain = Gain5;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) prod_q <= ProdW'(sample_q) * ProdW'(gain);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide the product by the calibration divisor through the
  // reciprocal multiply; the quotient always fits the millivolt width.
  // ---------------------------------------------------------------------------
  logic [CalProdW-1:0] cal_prod;
  logic [MvW-1:0]      mv2_q;

  assign cal_prod = CalProdW'(prod_q) * CalProdW'(CalRecip);

  always_ff @(posedge clk_i) begin
    if (rdy2) mv2_q <= cal_prod[CalShift +: MvW];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: window bookkeeping. The first sample of a window seeds the sum,
  // the maximum and the minimum, so nothing carries over from the last window.
  // On the last sample the trimmed sum is registered for the divide.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [MvW-1:0]  max_q, max_d;
  logic [MvW-1:0]  min_q, min_d;
  logic            first, last, acc_en;
  logic [SumW-1:0] mv_ext;

  logic [MvW-1:0]  mv3_q;
  logic [SumW-1:0] trim_q;
  logic            done3_q;

  assign acc_en = rdy3 && v2_q;
  assign first  = (cnt_q == '0);
  assign last   = (cnt_q == LastCnt);
  assign mv_ext = SumW'(mv2_q);

  always_comb begin
    sum_d = first ? mv_ext : sum_q + mv_ext;
    max_d = (first || (mv2_q > max_q)) ? mv2_q : max_q;
    min_d = (first || (mv2_q < min_q)) ? mv2_q : min_q;
    cnt_d = last ? '0 : cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      max_q <= '0;
      min_q <= '0;
    end else if (acc_en) begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  // Both extremes are members of a full window, so the trimmed sum used at its close never underflows.
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      mv3_q   <= mv2_q;
      trim_q  <= sum_d - SumW'(max_d) - SumW'(min_d);
      done3_q <= last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide the trimmed sum by the window length less two through a
  // reciprocal multiply and load the result register. The average reads zero
  // on items that do not close a window.
  // ---------------------------------------------------------------------------
  logic [AvgProdW-1:0] avg_prod;
  logic [AvgProdW-1:0] avg_shift;
  logic [MvW-1:0]      instant_q;
  logic [MvW-1:0]      average_q;
  logic                done4_q;

  assign avg_prod  = AvgProdW'(trim_q) * AvgProdW'(AvgRecip);
  assign avg_shift = avg_prod >> AvgShift;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      instant_q <= mv3_q;
      average_q <= done3_q ? avg_shift[MvW-1:0] : '0;
      done4_q   <= done3_q;
    end
  end

  assign result_o.valid       = v4_q;
  assign result_o.instant_mv  = instant_q;
  assign result_o.average_mv  = average_q;
  assign result_o.window_done = done4_q;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `TMPV_ASSERT_SAME(a_avg_zero_mid_window, clk_i, rst_ni,
                    result_o.valid && !result_o.window_done, result_o.average_mv == '0)
  `TMPV_ASSERT_NEXT(a_window_wraps, clk_i, rst_ni,
                    acc_en && last, cnt_q == '0)
  `TMPV_ASSERT_NEXT(a_extremes_ordered, clk_i, rst_ni,
                    acc_en, max_q >= min_q)

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// One result item as the block should present it.
typedef struct packed {
  logic [15:0] instant_mv;
  logic [15:0] average_mv;
  logic        window_done;
} voltage_result_t;

// Scoreboard: tracks the calibration window on the input side and holds the
// results still owed by the block, oldest first.
class trimmed_mean_tracker;
  int unsigned     window_len;
  int unsigned     fill;
  int unsigned     mv_sum;
  int unsigned     mv_max;
  int unsigned     mv_min;
  int unsigned     mismatches;
  voltage_result_t expected_results[$];

  function new(int unsigned len);
    window_len = len;
    fill       = 0;
    mv_sum     = 0;
    mv_max     = 0;
    mv_min     = 0;
    mismatches = 0;
  endfunction

  static function int unsigned to_millivolts(int unsigned code);
    int unsigned gain;
    if (code <= 498) gain = 55573;
    else if (code <= 639) gain = 56500;
    else if (code <= 849) gain = 56625;
    else if (code <= 1060) gain = 56750;
    else if (code <= 1266) gain = 56875;
    else gain = 57000;
    return (code * gain) / 4059;
  endfunction

  function void note_sample(logic [11:0] code);
    voltage_result_t owed;
    int unsigned     mv;
    int unsigned     trimmed;
    mv = to_millivolts(code);
    // The first sample of a window seeds the extremes.
    if (fill == 0) begin
      mv_sum = mv;
      mv_max = mv;
      mv_min = mv;
    end else begin
      mv_sum += mv;
      if (mv > mv_max) mv_max = mv;
      if (mv < mv_min) mv_min = mv;
    end
    owed.instant_mv  = 16'(mv);
    owed.average_mv  = '0;
    owed.window_done = 1'b0;
    if (fill + 1 >= window_len) begin
      trimmed = (mv_sum - mv_max - mv_min) / (window_len - 2);
      if (trimmed > 32'hFFFF) trimmed = 32'hFFFF;
      owed.average_mv  = 16'(trimmed);
      owed.window_done = 1'b1;
      fill = 0;
    end else begin
      fill++;
    end
    expected_results.push_back(owed);
  endfunction

  task report_mismatch(string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(logic [15:0] instant_mv, logic [15:0] average_mv, logic window_done);
    voltage_result_t owed;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending (instant %0d)", instant_mv));
    end else begin
      owed = expected_results.pop_front();
      if (instant_mv !== owed.instant_mv)
        report_mismatch($sformatf("instant_mv %0d, want %0d", instant_mv, owed.instant_mv));
      if (average_mv !== owed.average_mv)
        report_mismatch($sformatf("average_mv %0d, want %0d", average_mv, owed.average_mv));
      if (window_done !== owed.window_done)
        report_mismatch($sformatf("window_done %0b, want %0b", window_done,
                                  owed.window_done));
    end
  endtask
endclass

module tb_top;
  import tmpv_pkg::*;

  localparam int unsigned WindowLen     = 12;
  // Cycles with no item moving on either side before the run is declared hung.
  // The slowest legal gap is the long receiver hold plus a long random stall.
  localparam int unsigned IdleLimit     = 2000;
  // Length of the deliberate receiver hold-off; far longer than the pipe.
  localparam int unsigned HoldCycles    = 64;
  localparam int unsigned ItemsPerPhase = 360;
  // Wait at the end, after the last pending result has been checked.
  localparam int unsigned DrainCycles   = 16;

  logic clk_i;
  logic rst_ni;

  tmpv_sample_if sample_ch ();
  tmpv_result_if result_ch ();

  trimmed_mean_piecewise_voltage_unit #(
    .WINDOW_LEN(WindowLen)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_ch),
    .result_o(result_ch)
  );

  trimmed_mean_tracker tracker = new(WindowLen);

  // Idle rates in percent for each side; changed between phases.
  int unsigned        src_idle_pct  = 34;
  int unsigned        sink_idle_pct = 88;
  // The sender bumps this to ask the receiver for one long hold-off.
  int unsigned        stall_requests = 0;
  int unsigned        stall_served   = 0;
  int unsigned        quiet_cycles   = 0;
  logic [SampleW-1:0] last_code      = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Picks the next random code. Half the codes are uniform over the full range,
  // which exercises every bit; the rest sit on the segment edges, at the
  // ends of the range, or repeat the previous code so that windows holding
  // equal values, and thus ties for the maximum and minimum, show up often.
  function automatic logic [SampleW-1:0] pick_code();
    logic [SampleW-1:0] tops [5];
    logic [SampleW-1:0] code;
    int unsigned        mode;
    tops = '{Seg0Top, Seg1Top, Seg2Top, Seg3Top, Seg4Top};
    mode = $urandom_range(9);
    if (mode <= 4) begin
      code = SampleW'($urandom);
    end else if (mode <= 6) begin
      code = SampleW'(int'(tops[$urandom_range(4)]) + int'($urandom_range(4)) - 2);
    end else if (mode == 7) begin
      code = $urandom_range(1) ? SampleW'($urandom_range(3))
                               : SampleW'(4095 - $urandom_range(3));
    end else begin
      code = last_code;
    end
    last_code = code;
    return code;
  endfunction

  // Offers one item and returns at the falling edge after it is taken.
  // Valid stays high when the next call does not idle, so back-to-back
  // items go out without a bubble.
  task automatic send_sample(input logic [SampleW-1:0] code);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid  = 1'b0;
      sample_ch.sample = SampleW'($urandom);
      @(negedge clk_i);
    end
    sample_ch.valid  = 1'b1;
    sample_ch.sample = code;
    do @(posedge clk_i); while (!sample_ch.ready);
    tracker.note_sample(code);
    @(negedge clk_i);
  endtask

  // Receiver: ready changes at the falling edge only. When a hold-off is
  // requested it keeps ready low for a long count of its own, so the pipe
  // fills and the block has to push back on the sender.
  initial begin : sink_driver
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_requests != stall_served) begin
        stall_served    = stall_requests;
        result_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      result_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Every result item taken at a rising edge is checked against the oldest
  // pending expectation.
  always @(posedge clk_i) begin
    if (result_ch.valid && result_ch.ready)
      tracker.check_result(result_ch.instant_mv, result_ch.average_mv,
                           result_ch.window_done);
  end

  // Watchdog on progress: any item moving on either channel restarts it.
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    rst_ni           = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // First window: both ends of the code range and both sides of every
    // segment edge, so each gain word is used and the trim drops the
    // full-scale and zero samples.
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd498);
    send_sample(12'd499);
    send_sample(12'd639);
    send_sample(12'd640);
    send_sample(12'd849);
    send_sample(12'd850);
    send_sample(12'd1060);
    send_sample(12'd1061);
    send_sample(12'd1266);
    send_sample(12'd1267);
    // Second window: all values equal. Its extremes must be seeded from its
    // own first sample, not carried over from the wide window before it, and
    // the maximum and the minimum each still remove one sample.
    repeat (WindowLen) send_sample(12'hAAA);

    // Random phases: sender slow and receiver very slow, then the reverse,
    // then both at full rate, opened by a long receiver hold-off.
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 0) begin
        src_idle_pct  = 34;
        sink_idle_pct = 88;
      end else if (phase == 1) begin
        src_idle_pct  = 88;
        sink_idle_pct = 34;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_requests++;
      end
      repeat (ItemsPerPhase) send_sample(pick_code());
    end
    sample_ch.valid = 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
